// File: sv/ahfe_pkg.sv
// Types, constants and helper functions shared by the HDLC framing encoder.
`default_nettype none

package ahfe_pkg;

    // Framing constants.
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_START = 16'hFFFF;
    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam logic [31:0] ESC_MAP_RESET = 32'hFFFF_FFFF;

    // One framing job handed from the front part to the back part.
    typedef struct packed {
        logic        open_flag;  // emit an opening flag first
        logic        present;    // a payload byte follows
        logic [7:0]  data;       // payload byte
        logic        last;       // append FCS and closing flag
        logic [15:0] fcs;        // complemented FCS, valid when last is set
    } t_cmd;

    // Output steps of one job.
    typedef enum logic [2:0] {
        ST_OPEN,
        ST_DATA,
        ST_FCS_LO,
        ST_FCS_HI,
        ST_CLOSE
    } t_step;

    // Reflected CRC-16 update over one byte, one bit per iteration.
    function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] c;
        c = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // True when a byte must be sent as an escape pair.
    function automatic logic needs_escape(input logic [7:0] b, input logic [31:0] esc_map);
        logic r;
        r = 1'b0;
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            r = 1'b1;
        end else if (b[7:5] == 3'b000) begin
            r = esc_map[b[4:0]];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/ahfe_if.sv
// Valid/ready channel interfaces for input items and encoded line bytes.
`default_nettype none

interface ahfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       byte_present;
    logic       frame_end;

    modport source (output valid, output in_byte, output byte_present, output frame_end,
                    input ready);
    modport sink   (input valid, input in_byte, input byte_present, input frame_end,
                    output ready);
endinterface

interface ahfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       closes_frame;
    logic       run_end;

    modport source (output valid, output out_byte, output closes_frame, output run_end,
                    input ready);
    modport sink   (input valid, input out_byte, input closes_frame, input run_end,
                    output ready);
endinterface

`default_nettype wire

// File: sv/async_hdlc_frame_encoder.sv
// Top level of the asynchronous HDLC framing encoder with FCS-16.
//
//   Channel   Dir  Handshake     Payload
//   i_item    in   valid/ready   in_byte[7:0], byte_present, frame_end
//   o_result  out  valid/ready   out_byte[7:0], closes_frame, run_end
//   i_cfg_*   in   write enable  escape map [31:0]
//
// The output side sends one line byte per cycle while the sink is ready; an item gives at most
// a flag, an escaped data byte, two escaped FCS bytes and a flag; an idle item gives none.
// The front takes one item per cycle while the job queue (QUEUE_DEPTH entries) has room,
// so the sustained rate is set by the back sequencer's one byte per cycle.
// Reset is synchronous: it empties the queue, ends any open frame and sets the map to all ones.
// A stalled output holds its byte in the output register; the queue absorbs short stalls.
`default_nettype none

module async_hdlc_frame_encoder
    import ahfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    ahfe_in_if.sink          i_item,
    ahfe_out_if.source       o_result
);

    logic [31:0] r_esc_map;
    logic        push;
    t_cmd        push_cmd;
    logic        q_full;
    logic        q_valid;
    t_cmd        q_head;
    logic        pop;

    // Escape map register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_map <= ESC_MAP_RESET;
        end else if (i_cfg_we) begin
            r_esc_map <= i_cfg_wdata;
        end
    end

    ahfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    ahfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .i_pop      (pop)
    );

    ahfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_esc_map (r_esc_map),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// File: sv/ahfe_front.sv
// Front part: accepts items, tracks frame state and the running FCS, issues jobs.
`default_nettype none

module ahfe_front
    import ahfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ahfe_in_if.sink   i_item,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_cmd      o_push_cmd
);

    logic        r_inside;
    logic [15:0] r_fcs;
    logic        n_inside;
    logic [15:0] n_fcs;
    logic        accept;
    logic [15:0] base_fcs;
    logic [15:0] upd_fcs;

    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && !i_q_full;

    // Work out the job and the next frame state for the offered item.
    always_comb begin
        base_fcs = r_inside ? r_fcs : FCS_START;
        upd_fcs  = i_item.byte_present ? fcs_update(base_fcs, i_item.in_byte) : base_fcs;

        o_push_cmd.open_flag = !r_inside;
        o_push_cmd.present   = i_item.byte_present;
        o_push_cmd.data      = i_item.in_byte;
        o_push_cmd.last      = i_item.frame_end;
        o_push_cmd.fcs       = ~upd_fcs;

        // An item with neither a byte nor an end mark is dropped.
        o_push   = accept && (i_item.byte_present || i_item.frame_end);
        n_inside = r_inside;
        n_fcs    = r_fcs;
        if (o_push) begin
            if (i_item.frame_end) begin
                n_inside = 1'b0;
                n_fcs    = FCS_START;
            end else begin
                n_inside = 1'b1;
                n_fcs    = upd_fcs;
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_fcs    <= FCS_START;
        end else begin
            r_inside <= n_inside;
            r_fcs    <= n_fcs;
        end
    end

endmodule

`default_nettype wire

// File: sv/ahfe_queue.sv
// Short job queue between the front and back parts.
`default_nettype none

module ahfe_queue
    import ahfe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_push_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_head,
    input  wire logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if ((i_push && !o_full) && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!(i_push && !o_full) && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/ahfe_back.sv
// Back part: emits each job's needed flag, data, FCS and closing flag, escaping bytes.
`default_nettype none

module ahfe_back
    import ahfe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_esc_map,
    input  wire logic        i_q_valid,
    input  wire t_cmd        i_q_head,
    output logic             o_pop,
    ahfe_out_if.source       o_result
);

    t_step       r_step;
    t_step       n_step;
    logic        r_esc2;
    logic        n_esc2;
    logic        r_busy;
    logic        n_busy;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [7:0]  r_out_byte;
    logic [7:0]  n_out_byte;
    logic        r_closes;
    logic        n_closes;
    logic        r_run_end;
    logic        n_run_end;

    logic        slot_free;
    logic        emit;
    logic [7:0]  cur_byte;
    logic        esc_need;
    logic        step_done;
    logic        cmd_done;
    logic [7:0]  emit_byte;
    t_step       next_step;
    t_step       first_step;

    assign o_result.valid        = r_out_valid;
    assign o_result.out_byte     = r_out_byte;
    assign o_result.closes_frame = r_closes;
    assign o_result.run_end      = r_run_end;

    // Sequencer: one line byte per cycle while busy and the output register has room.
    always_comb begin
        slot_free = !r_out_valid || o_result.ready;
        emit      = r_busy && slot_free;

        cur_byte  = FLAG_BYTE;
        next_step = ST_CLOSE;
        cmd_done  = 1'b1;
        unique case (r_step)
            ST_OPEN: begin
                cur_byte  = FLAG_BYTE;
                next_step = r_cmd.present ? ST_DATA : ST_FCS_LO;
                cmd_done  = 1'b0;
            end
            ST_DATA: begin
                cur_byte  = r_cmd.data;
                next_step = ST_FCS_LO;
                cmd_done  = !r_cmd.last;
            end
            ST_FCS_LO: begin
                cur_byte  = r_cmd.fcs[7:0];
                next_step = ST_FCS_HI;
                cmd_done  = 1'b0;
            end
            ST_FCS_HI: begin
                cur_byte  = r_cmd.fcs[15:8];
                next_step = ST_CLOSE;
                cmd_done  = 1'b0;
            end
            ST_CLOSE: begin
                cur_byte  = FLAG_BYTE;
                next_step = ST_CLOSE;
                cmd_done  = 1'b1;
            end
            default: begin
                cur_byte  = FLAG_BYTE;
                next_step = ST_CLOSE;
                cmd_done  = 1'b1;
            end
        endcase

        // Flags go out raw; everything else may become an escape pair.
        esc_need = (r_step != ST_OPEN) && (r_step != ST_CLOSE)
                   && needs_escape(cur_byte, i_esc_map);
        if (esc_need && !r_esc2) begin
            emit_byte = ESC_BYTE;
            step_done = 1'b0;
        end else begin
            emit_byte = r_esc2 ? (cur_byte ^ ESC_XOR) : cur_byte;
            step_done = 1'b1;
        end
        cmd_done = cmd_done && step_done;

        // Take the next job when idle or when the current one finishes now.
        o_pop = i_q_valid && (!r_busy || (emit && cmd_done));

        first_step = i_q_head.open_flag ? ST_OPEN :
                     (i_q_head.present ? ST_DATA : ST_FCS_LO);

        n_step = r_step;
        n_esc2 = r_esc2;
        n_busy = r_busy;
        n_cmd  = r_cmd;
        if (emit) begin
            if (step_done) begin
                n_esc2 = 1'b0;
                n_step = next_step;
                if (cmd_done) begin
                    n_busy = 1'b0;
                end
            end else begin
                n_esc2 = 1'b1;
            end
        end
        if (o_pop) begin
            n_cmd  = i_q_head;
            n_step = first_step;
            n_esc2 = 1'b0;
            n_busy = 1'b1;
        end

        // Output register.
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_closes    = r_closes;
        n_run_end   = r_run_end;
        if (slot_free) begin
            n_out_valid = emit;
            n_out_byte  = emit_byte;
            n_closes    = (r_step == ST_CLOSE);
            n_run_end   = cmd_done;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_OPEN;
            r_esc2      <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_esc2      <= n_esc2;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_closes   <= n_closes;
        r_run_end  <= n_run_end;
    end

`ifndef NO_ASSERTIONS
    // A closing flag is always the raw flag byte and ends its item's results.
    a_close_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_closes) |-> (r_out_byte == FLAG_BYTE && r_run_end))
        else $error("closing byte is not a final flag");

    // The second half of an escape pair only occurs on escapable steps.
    a_esc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc2 |-> (r_busy && r_step != ST_OPEN && r_step != ST_CLOSE))
        else $error("escape pending on a flag step");

    // An escape byte is always followed by the escaped byte of the same job.
    a_esc_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !step_done) |=> (r_esc2 && r_busy))
        else $error("escape pair broken");
`endif

endmodule

`default_nettype wire
